// File: hw/rtl/spjt_pkg.sv
// Shared constants and types for the sample histogram and jitter tracker.
`default_nettype none

package spjt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int SAMPLE_BITS = 12;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
	localparam int COUNT_W     = 32;
	localparam int STAMP_W     = 32;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// One table entry: sample value and its saturating count
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic [COUNT_W-1:0]     count;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_GAP   = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_RDATA = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/sample_pmf_and_jitter_tracker_core.sv
// Sample value histogram table with timestamp interval jitter tracking.
`default_nettype none

// Each request on the slave stream either records a converter sample or reads
// one entry of the histogram table; each request yields exactly one result on
// the master stream. A record request first folds the gap between the previous
// and the current down-counting timestamp (previous minus current, modulo 2^32)
// into the minimum and maximum intervals, then walks the table of distinct
// values in fill order, one entry per cycle through the table's single read
// port, comparing each stored value against the sample. A match raises that
// entry's saturating count; a miss places the sample in the next free entry with
// a count of one, or, with the table full, drops it and flags the drop. Jitter is
// maximum minus minimum interval and reads 0 until three samples have been seen.
// A record request passes through acceptance, the interval update, a table walk
// over up to fill_level entries and the result load; a read request passes
// through acceptance, the table read, the read-back and the result load. Record
// time grows with fill level, as the walk uses the one memory port. The block
// takes one request at a time; tready is high only while idle, but a finished
// result waiting in the output register does not hold off the next request.
// Counts start cleared through the fill level alone: no clearing pass is run.
module sample_pmf_and_jitter_tracker_core
	import spjt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [11:0] sample, [43:12] timestamp, [53:44] entry_index, [55:54] zero
	input  wire logic [55:0] s_axis_tdata,
	// [0] op
	input  wire logic [0:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [11:0] entry_value, [43:12] entry_count, [54:44] entries_used,
	// [86:55] jitter, [87] zero
	output logic [87:0]      m_axis_tdata,
	// [0] entry_valid, [1] dropped
	output logic [1:0]       m_axis_tuser
);

	// Table memory
	entry_t mem [TABLE_DEPTH];
	entry_t mem_rd_q;
	entry_t mem_wd;
	logic   mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_ra;

	// Control
	state_t state_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] scan_q;
	logic              rd_vld_q;
	logic [IDX_W-1:0]  rd_idx_q;

	// Latched request
	logic                   op_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [STAMP_W-1:0]     stamp_q;
	logic [IDX_W-1:0]       idx_q;

	// Interval tracking
	logic [STAMP_W-1:0] last_q;
	logic               have_last_q;
	logic [STAMP_W-1:0] min_q;
	logic [STAMP_W-1:0] max_q;
	logic [STAMP_W-1:0] gap;
	logic [STAMP_W-1:0] jitter;

	// Result waiting for the output register
	logic [SAMPLE_BITS-1:0] res_value_q;
	logic [COUNT_W-1:0]     res_count_q;
	logic                   res_valid_q;
	logic                   res_drop_q;

	// Output register
	logic                   m_valid_q;
	logic [SAMPLE_BITS-1:0] out_value_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic                   out_valid_q;
	logic                   out_drop_q;
	logic [FILL_W-1:0]      out_used_q;
	logic [STAMP_W-1:0]     out_jitter_q;

	logic                   in_take;
	logic                   out_free;
	logic                   hit;
	logic [COUNT_W-1:0]     count_inc;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign gap    = last_q - stamp_q;
	assign jitter = (max_q >= min_q) ? (max_q - min_q) : '0;

	// Shared compare: current read-back entry against the sample
	assign hit       = rd_vld_q && (mem_rd_q.value == sample_q);
	assign count_inc = (mem_rd_q.count == '1) ? mem_rd_q.count
	                                          : mem_rd_q.count + 1'b1;

	assign mem_ra = (state_q == ST_READ) ? idx_q : scan_q[IDX_W-1:0];

	// Table write: bump a matched count or place a new value
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_idx_q;
		mem_wd = '{value: sample_q, count: count_inc};
		if (state_q == ST_SCAN) begin
			if (hit) begin
				mem_we = 1'b1;
			end else if (scan_q >= fill_q && fill_q < FILL_W'(TABLE_DEPTH)) begin
				mem_we = 1'b1;
				mem_wa = fill_q[IDX_W-1:0];
				mem_wd = '{value: sample_q, count: COUNT_W'(1)};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[mem_ra];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			scan_q      <= '0;
			rd_vld_q    <= 1'b0;
			rd_idx_q    <= '0;
			have_last_q <= 1'b0;
			last_q      <= '0;
			min_q       <= '1;
			max_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one is loaded this cycle
			if (m_valid_q && m_axis_tready && state_q != ST_EMIT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= (s_axis_tuser[0] == OP_READ) ? ST_READ : ST_GAP;
					end
				end
				ST_GAP: begin
					// Fold the new gap into both bounds independently
					if (have_last_q) begin
						if (gap > max_q) begin
							max_q <= gap;
						end
						if (gap < min_q) begin
							min_q <= gap;
						end
					end
					last_q      <= stamp_q;
					have_last_q <= 1'b1;
					scan_q      <= '0;
					rd_vld_q    <= 1'b0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit) begin
						rd_vld_q <= 1'b0;
						state_q  <= ST_EMIT;
					end else if (scan_q < fill_q) begin
						// Advance the walk: request the next entry
						rd_vld_q <= 1'b1;
						rd_idx_q <= scan_q[IDX_W-1:0];
						scan_q   <= scan_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						if (fill_q < FILL_W'(TABLE_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q     <= s_axis_tuser[0];
			sample_q <= s_axis_tdata[11:0];
			stamp_q  <= s_axis_tdata[43:12];
			idx_q    <= s_axis_tdata[53:44];
		end
		if (state_q == ST_SCAN) begin
			if (hit) begin
				res_value_q <= mem_rd_q.value;
				res_count_q <= count_inc;
				res_valid_q <= 1'b1;
				res_drop_q  <= 1'b0;
			end else if (scan_q >= fill_q) begin
				res_value_q <= sample_q;
				if (fill_q < FILL_W'(TABLE_DEPTH)) begin
					res_count_q <= COUNT_W'(1);
					res_valid_q <= 1'b1;
					res_drop_q  <= 1'b0;
				end else begin
					// Full table: drop the sample
					res_count_q <= '0;
					res_valid_q <= 1'b0;
					res_drop_q  <= 1'b1;
				end
			end
		end
		if (state_q == ST_RDATA) begin
			res_drop_q <= 1'b0;
			if (FILL_W'(idx_q) < fill_q) begin
				res_value_q <= mem_rd_q.value;
				res_count_q <= mem_rd_q.count;
				res_valid_q <= 1'b1;
			end else begin
				res_value_q <= '0;
				res_count_q <= '0;
				res_valid_q <= 1'b0;
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			out_value_q  <= res_value_q;
			out_count_q  <= res_count_q;
			out_valid_q  <= res_valid_q;
			out_drop_q   <= res_drop_q && (op_q == OP_RECORD);
			out_used_q   <= fill_q;
			out_jitter_q <= jitter;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, out_jitter_q, out_used_q, out_count_q, out_value_q};
	assign m_axis_tuser  = {out_drop_q, out_valid_q};

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(TABLE_DEPTH))
		else $error("fill level beyond table depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill level moved by other than one");

	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && m_axis_tdata[43:12] == '0))
		else $error("dropped result carries an entry");
`endif

endmodule

`default_nettype wire

// File: sim/sample_pmf_and_jitter_tracker_scoreboard.sv
// Scoreboard for the sample histogram and jitter tracker: predicts every result and compares.
`timescale 1ns / 1ps

module sample_pmf_and_jitter_tracker_scoreboard
	import spjt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,
	input  wire logic [0:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [87:0] m_axis_tdata,
	input  wire logic [1:0]  m_axis_tuser,
	output int               fault_count,
	output int               reports_due
);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic [COUNT_W-1:0]     count;
		logic                   valid;
		logic                   dropped;
		logic [FILL_W-1:0]      used;
		logic [STAMP_W-1:0]     jitter;
	} entry_report_t;

	// Own copy of the histogram and interval state
	logic [SAMPLE_BITS-1:0] value_tab [TABLE_DEPTH];
	logic [COUNT_W-1:0]     count_tab [TABLE_DEPTH];
	logic [FILL_W-1:0]      fill_level;
	logic [STAMP_W-1:0]     last_stamp;
	logic [STAMP_W-1:0]     min_gap;
	logic [STAMP_W-1:0]     max_gap;
	logic                   have_stamp;

	entry_report_t due_reports [$];
	entry_report_t want;

	initial begin
		fault_count = 0;
		reports_due = 0;
	end

	task automatic report_fault(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v)
			report_fault($sformatf("%s expected %h got %h", name, exp_v, got_v));
	endtask

	// Work out the result of one request and advance the histogram state
	task automatic tally_request(input logic op, input logic [SAMPLE_BITS-1:0] smp,
			input logic [STAMP_W-1:0] ts, input logic [IDX_W-1:0] idx,
			output entry_report_t rep);
		int hit;
		int k;
		logic [STAMP_W-1:0] gap;
		rep = '0;
		if (op == OP_READ) begin
			if (idx < fill_level) begin
				rep.value = value_tab[idx];
				rep.count = count_tab[idx];
				rep.valid = 1'b1;
			end
		end else begin
			if (have_stamp) begin
				gap = last_stamp - ts;
				if (gap > max_gap)
					max_gap = gap;
				if (gap < min_gap)
					min_gap = gap;
			end
			last_stamp = ts;
			have_stamp = 1'b1;
			hit = -1;
			k = 0;
			while (k < fill_level && hit < 0) begin
				if (value_tab[k] == smp)
					hit = k;
				k++;
			end
			if (hit >= 0) begin
				if (count_tab[hit] != '1)
					count_tab[hit] = count_tab[hit] + 1'b1;
			end else if (fill_level < TABLE_DEPTH) begin
				hit = fill_level;
				value_tab[hit] = smp;
				count_tab[hit] = 1;
				fill_level = fill_level + 1'b1;
			end
			if (hit >= 0) begin
				rep.value = value_tab[hit];
				rep.count = count_tab[hit];
				rep.valid = 1'b1;
			end else begin
				rep.value   = smp;
				rep.dropped = 1'b1;
			end
		end
		rep.used   = fill_level;
		rep.jitter = (max_gap >= min_gap) ? max_gap - min_gap : '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++)
				count_tab[k] = '0;
			fill_level = '0;
			last_stamp = '0;
			have_stamp = 1'b0;
			min_gap    = '1;
			max_gap    = '0;
			due_reports.delete();
			reports_due <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				tally_request(s_axis_tuser[0], s_axis_tdata[11:0], s_axis_tdata[43:12],
					s_axis_tdata[53:44], want);
				due_reports.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_reports.size() == 0) begin
					report_fault("result with no request outstanding");
				end else begin
					want = due_reports.pop_front();
					check_field("entry_value", want.value, m_axis_tdata[11:0]);
					check_field("entry_count", want.count, m_axis_tdata[43:12]);
					check_field("entries_used", want.used, m_axis_tdata[54:44]);
					check_field("jitter", want.jitter, m_axis_tdata[86:55]);
					check_field("entry_valid", want.valid, m_axis_tuser[0]);
					check_field("dropped", want.dropped, m_axis_tuser[1]);
				end
			end
			reports_due <= due_reports.size();
		end
	end

endmodule

// File: sim/sample_pmf_and_jitter_tracker_core_tb.sv
// Top of the testbench for the sample histogram and jitter tracker: stimulus and verdict.
`timescale 1ns / 1ps

module sample_pmf_and_jitter_tracker_core_tb;
	import spjt_pkg::*;

	// Hang guard: each record walks at most the full table, and the run carries
	// under 600 requests, so this is several times the slowest pass.
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int POOL_N      = 16;
	localparam int DRAIN_WAIT  = 1100;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	int fault_count;
	int reports_due;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// Stimulus bookkeeping: which sample values are held in the table, so that
	// reads can aim mostly at filled entries or the first free one.
	bit          seen [4096];
	int          nseen = 0;
	logic [31:0] stamp_now = '0;
	logic [11:0] pool [POOL_N];

	sample_pmf_and_jitter_tracker_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	sample_pmf_and_jitter_tracker_scoreboard watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fault_count   (fault_count),
		.reports_due   (reports_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure: drop tready at random, every cycle afresh, so that
	// stalls land on whatever the block happens to be doing.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. Idle gaps come
	// first; tvalid is only lowered when a gap is actually taken, so a request
	// that follows straight on keeps tvalid high across the edge.
	task automatic send_request(input logic op, input logic [11:0] smp,
			input logic [31:0] ts, input logic [9:0] idx);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, idx, ts, smp};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Record request; the entry index field is noise here
	task automatic put_sample(input logic [11:0] smp, input logic [31:0] ts);
		if (!seen[smp] && nseen < TABLE_DEPTH) begin
			seen[smp] = 1'b1;
			nseen++;
		end
		stamp_now = ts;
		send_request(OP_RECORD, smp, ts, 10'($urandom));
	endtask

	// Read request; sample and timestamp fields are noise here
	task automatic put_read(input logic [9:0] idx);
		send_request(OP_READ, 12'($urandom), $urandom, idx);
	endtask

	// Mostly a steady down-count with some wander; now and then hold still,
	// leap anywhere, or step backwards so the gap wraps round.
	function automatic logic [31:0] next_stamp(input logic [31:0] prev);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return prev;
		if (pick < 9)
			return $urandom;
		if (pick < 12)
			return prev + $urandom_range(1, 50);
		return prev - $urandom_range(950, 1050);
	endfunction

	// Mixed traffic: records drawn mostly from a small pool so that counts climb
	// and the table stays short, the odd fresh value, and reads that mostly hit
	// filled entries or the first free one.
	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			if ($urandom_range(0, 3) == 0)
				put_read(10'($urandom));
			else
				put_read(10'($urandom_range(0, nseen)));
		end else if (pick < 85) begin
			put_sample(pool[$urandom_range(0, POOL_N - 1)], next_stamp(stamp_now));
		end else begin
			put_sample(12'($urandom), next_stamp(stamp_now));
		end
	endtask

	initial begin
		pool[0] = 12'h000;
		pool[1] = 12'hFFF;
		for (int k = 2; k < POOL_N; k++)
			pool[k] = 12'($urandom);

		tx_idle_pct = 35;
		rx_idle_pct = 65;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads of an empty table, then the first sample with no
		// interval, the first interval (jitter still zero), a huge gap, a zero
		// gap, a gap that wraps round, and count increments.
		put_read(10'd0);
		put_read(10'd1023);
		put_sample(12'h000, 32'hFFFF_FFFF);
		put_read(10'd0);
		put_sample(12'hFFF, 32'hFFFF_FC17);
		put_sample(12'h000, 32'h0000_0000);
		put_sample(12'hFFF, 32'h0000_0000);
		put_sample(12'hA5A, 32'hFFFF_FFFF);
		put_sample(12'h5A5, 32'h8000_0000);
		put_sample(12'h000, 32'h7FFF_FC00);
		put_sample(12'h000, 32'h7FFF_F800);
		put_sample(12'hFFF, 32'h7FFF_F3F0);
		for (int k = 0; k < 6; k++)
			put_read(10'(k));
		put_read(10'd1023);
		put_read(10'h2AA);
		put_read(10'h155);

		repeat (190) random_item();

		// Swap the idling: sender now sparse, receiver mostly ready
		tx_idle_pct <= 65;
		rx_idle_pct <= 35;
		repeat (190) random_item();

		// No idling from here on
		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		repeat (180) random_item();

		put_read(10'd1023);

		// Drain: hold tvalid low, let the count of outstanding results settle,
		// then give the block time to show any stray result.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fault_count == 0 && reports_due == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/spjt_pkg.sv
hw/rtl/sample_pmf_and_jitter_tracker_core.sv
sim/sample_pmf_and_jitter_tracker_scoreboard.sv
sim/sample_pmf_and_jitter_tracker_core_tb.sv
